/* rtl/dstc_pkg.sv */
// shared types, constants and codes of the dedup slot table
// no dependencies
package dstc_pkg;

  localparam int SLOT_COUNT   = 1024;
  localparam int SLOT_AW      = $clog2(SLOT_COUNT);
  localparam int PROBE_WINDOW = 8;
  localparam int PROBE_CW     = $clog2(PROBE_WINDOW + 1);
  localparam int DIV_STEPS    = 64;
  localparam int DIV_CW       = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] OP_CLAIM   = 2'd0;
  localparam logic [1:0] OP_PUBLISH = 2'd1;
  localparam logic [1:0] OP_ABORT   = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [1:0] ROLE_HIT   = 2'd0;
  localparam logic [1:0] ROLE_WAIT  = 2'd1;
  localparam logic [1:0] ROLE_FETCH = 2'd2;
  localparam logic [1:0] ROLE_ACK   = 2'd3;

  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_FETCHING = 2'd1;
  localparam logic [1:0] ST_READY    = 2'd2;

  localparam logic [1:0] CFG_TTL      = 2'd0;
  localparam logic [1:0] CFG_TAKEOVER = 2'd1;
  localparam logic [1:0] CFG_ARENA    = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key_id;
    logic [31:0] key_idx;
    logic        key_kind;
    logic [63:0] now_ms;
    logic [31:0] size_bytes;
    logic        exact_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  role;
    logic        applied;
    logic [39:0] payload_offset;
    logic [31:0] payload_length;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key_id;
    logic [31:0] key_idx;
    logic        kind;
    logic [63:0] start_time;
    logic [31:0] length;
    logic [39:0] offset;
    logic [63:0] lap_mark;
  } slot_rec_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic chk;
    logic eval;
    logic tko;
    logic rsv;
    logic abt;
    logic div_go;
    logic div_sel;
    logic lap;
    logic pub;
    logic clr;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       oversize;
    logic       probe_last;
    logic       clr_last;
    logic       match_fetch;
    logic       match_ready;
    logic       hit_ok;
    logic       stale;
    logic       rsv_found;
    logic       arena_zero;
    logic       div_done;
  } dp_sts_t;

endpackage

/* rtl/dstc_rem_div.sv */
// restoring remainder unit, one quotient bit per cycle
// depends on dstc_pkg
module dstc_rem_div import dstc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [40:0] divisor,
  output logic        done,
  output logic [40:0] rem
);

  logic [40:0]       rem_r, rem_nxt;
  logic [63:0]       dvd_r;
  logic [40:0]       dsr_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              run_r, done_r;
  logic [41:0]       trial;

  always_comb begin
    trial = {rem_r, dvd_r[63]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = 41'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[40:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        dvd_r <= dividend;
        dsr_r <= divisor;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[62:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* rtl/dstc_dpath.sv */
// datapath: slot memories, probe scan, checks, ring cursor and result register
// depends on dstc_pkg and dstc_rem_div
module dstc_dpath import dstc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  input  in_item_t  in_item,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [40:0] cfg_wdata,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [1:0] st_mem  [SLOT_COUNT];
  slot_rec_t  rec_mem [SLOT_COUNT];

  logic [31:0] ttl_r, tko_r;
  logic [40:0] arena_r;
  logic [63:0] cursor_r;
  in_item_t    it_r;

  logic [SLOT_AW-1:0]  pa_r, home, clr_r, match_idx_r, rsv_idx_r;
  logic [PROBE_CW-1:0] pc_r;
  logic [1:0]          rd_st_q, match_st_r;
  slot_rec_t           rd_rec_q, match_rec_r, wr_rec;
  logic                match_r, rsv_r, hit_ok_r, stale_r;
  logic [63:0]         end_r;
  logic [39:0]         off_r;
  logic                out_valid_r;
  out_item_t           out_r, res;

  logic        key_eq, can_rsv, hit_ok_c;
  logic [31:0] hash;
  logic [63:0] age_rd, age_m, arena64, len64, need;
  logic [41:0] lap_sum;
  logic        div_done;
  logic [40:0] div_rem;
  logic [63:0] div_dvd;

  // home slot of the incoming beat, taken as the first probe address
  assign hash = in_item.key_id[31:0] ^ in_item.key_id[63:32] ^ in_item.key_idx ^
                {18'd0, in_item.key_kind, 13'd0};
  assign home = hash[SLOT_AW-1:0];

  assign key_eq  = (rd_st_q != ST_EMPTY) && (rd_rec_q.key_id == it_r.key_id) &&
                   (rd_rec_q.key_idx == it_r.key_idx) &&
                   (rd_rec_q.kind == it_r.key_kind);
  assign age_rd  = it_r.now_ms - rd_rec_q.start_time;
  assign can_rsv = (rd_st_q == ST_EMPTY) ||
                   ((rd_st_q == ST_READY) && (age_rd > {32'd0, ttl_r}));

  assign age_m   = it_r.now_ms - match_rec_r.start_time;
  assign arena64 = {23'd0, arena_r};
  assign len64   = {32'd0, match_rec_r.length};
  assign lap_sum = {2'b0, match_rec_r.offset} + {10'd0, match_rec_r.length};

  always_comb begin
    hit_ok_c = (age_m <= {32'd0, ttl_r});
    if (it_r.exact_length && (match_rec_r.length != it_r.size_bytes)) hit_ok_c = 1'b0;
    if (match_rec_r.length > it_r.size_bytes) hit_ok_c = 1'b0;
    if (lap_sum > {1'b0, arena_r}) hit_ok_c = 1'b0;
    if ((cursor_r - match_rec_r.lap_mark) > (arena64 - len64)) hit_ok_c = 1'b0;
  end

  assign div_dvd = cmd.div_sel ? (end_r - {32'd0, it_r.size_bytes}) : cursor_r;

  dstc_rem_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (div_dvd),
    .divisor  (arena_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    if (({1'b0, div_rem} + {10'd0, it_r.size_bytes}) > {1'b0, arena_r}) begin
      need = (arena64 - {23'd0, div_rem}) + {32'd0, it_r.size_bytes};
    end else begin
      need = {32'd0, it_r.size_bytes};
    end
  end

  // memory write record
  always_comb begin
    wr_rec = match_rec_r;
    if (cmd.rsv) begin
      wr_rec.key_id     = it_r.key_id;
      wr_rec.key_idx    = it_r.key_idx;
      wr_rec.kind       = it_r.key_kind;
      wr_rec.start_time = it_r.now_ms;
      wr_rec.length     = '0;
      wr_rec.offset     = '0;
      wr_rec.lap_mark   = '0;
    end else if (cmd.pub) begin
      wr_rec.length     = it_r.size_bytes;
      wr_rec.offset     = div_rem[39:0];
      wr_rec.lap_mark   = end_r;
      wr_rec.start_time = it_r.now_ms;
    end else begin
      wr_rec.start_time = it_r.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) st_mem[clr_r] <= ST_EMPTY;
    else if (cmd.rsv) st_mem[rsv_idx_r] <= ST_FETCHING;
    else if (cmd.pub) st_mem[match_idx_r] <= ST_READY;
    else if (cmd.abt) st_mem[match_idx_r] <= ST_EMPTY;
    if (cmd.rsv) rec_mem[rsv_idx_r] <= wr_rec;
    else if (cmd.pub || cmd.tko) rec_mem[match_idx_r] <= wr_rec;
    if (cmd.rd) begin
      rd_st_q  <= st_mem[pa_r];
      rd_rec_q <= rec_mem[pa_r];
    end
  end

  // result of the current item
  always_comb begin
    res = '0;
    res.role = ROLE_ACK;
    unique case (it_r.opcode)
      OP_CLAIM: begin
        res.role = ROLE_FETCH;
        if (!sts.oversize && match_r) begin
          if (match_st_r == ST_READY && hit_ok_r) begin
            res.role           = ROLE_HIT;
            res.payload_offset = match_rec_r.offset;
            res.payload_length = match_rec_r.length;
          end else if (match_st_r == ST_FETCHING && !stale_r) begin
            res.role = ROLE_WAIT;
          end
        end
      end
      OP_PUBLISH: begin
        if (match_r && match_st_r == ST_FETCHING && arena_r != '0) begin
          res.applied        = 1'b1;
          res.payload_offset = off_r;
          res.payload_length = it_r.size_bytes;
        end
      end
      OP_ABORT: res.applied = match_r && (match_st_r == ST_FETCHING);
      default: res = res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r       <= 32'd5000;
      tko_r       <= 32'd2000;
      arena_r     <= 41'd536870912;
      cursor_r    <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TTL:      ttl_r   <= cfg_wdata[31:0];
          CFG_TAKEOVER: tko_r   <= cfg_wdata[31:0];
          CFG_ARENA:    arena_r <= cfg_wdata;
          default:      ttl_r   <= ttl_r;
        endcase
      end
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      if (cmd.pub) cursor_r <= end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r    <= in_item;
      match_r <= 1'b0;
      rsv_r   <= 1'b0;
      pc_r    <= '0;
      pa_r    <= home;
    end
    if (cmd.chk) begin
      pa_r <= pa_r + 1'b1;
      pc_r <= pc_r + 1'b1;
      if (key_eq && !match_r) begin
        match_r     <= 1'b1;
        match_idx_r <= pa_r;
        match_st_r  <= rd_st_q;
        match_rec_r <= rd_rec_q;
      end
      if (can_rsv && !rsv_r) begin
        rsv_r     <= 1'b1;
        rsv_idx_r <= pa_r;
      end
    end
    if (cmd.eval) begin
      hit_ok_r <= hit_ok_c;
      stale_r  <= age_m > {32'd0, tko_r};
    end
    if (cmd.lap) end_r <= cursor_r + need;
    if (cmd.pub) off_r <= div_rem[39:0];
    if (cmd.fin) out_r <= res;
  end

  always_comb begin
    sts             = '0;
    sts.opcode      = it_r.opcode;
    sts.oversize    = (it_r.size_bytes == '0) ||
                      ({8'd0, it_r.size_bytes} > arena_r[40:1]);
    sts.probe_last  = (pc_r == PROBE_CW'(PROBE_WINDOW - 1));
    sts.clr_last    = (clr_r == {SLOT_AW{1'b1}});
    sts.match_fetch = match_r && (match_st_r == ST_FETCHING);
    sts.match_ready = match_r && (match_st_r == ST_READY);
    sts.hit_ok      = hit_ok_r;
    sts.stale       = stale_r;
    sts.rsv_found   = rsv_r;
    sts.arena_zero  = (arena_r == '0);
    sts.div_done    = div_done;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* rtl/dstc_ctrl.sv */
// controller state machine sequencing clear, probe, check and write steps
// depends on dstc_pkg
module dstc_ctrl import dstc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_CHK, S_EVAL, S_ACT, S_TKO, S_RSV, S_ABT,
    S_DIV1, S_WAIT1, S_LAP, S_DIV2, S_WAIT2, S_PUB, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_RD;
      S_RD: begin
        if (sts.opcode == OP_NONE || (sts.opcode == OP_CLAIM && sts.oversize)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK:   state_nxt = sts.probe_last ? S_EVAL : S_RD;
      S_EVAL:  state_nxt = S_ACT;
      S_ACT: begin
        state_nxt = S_FIN;
        unique case (sts.opcode)
          OP_CLAIM: begin
            if (sts.match_fetch) begin
              if (sts.stale) state_nxt = S_TKO;
            end else if (!(sts.match_ready && sts.hit_ok) && sts.rsv_found) begin
              state_nxt = S_RSV;
            end
          end
          OP_PUBLISH: if (sts.match_fetch && !sts.arena_zero) state_nxt = S_DIV1;
          OP_ABORT:   if (sts.match_fetch) state_nxt = S_ABT;
          default:    state_nxt = S_FIN;
        endcase
      end
      S_TKO, S_RSV, S_ABT, S_PUB: state_nxt = S_FIN;
      S_DIV1:  state_nxt = S_WAIT1;
      S_WAIT1: if (sts.div_done) state_nxt = S_LAP;
      S_LAP:   state_nxt = S_DIV2;
      S_DIV2:  state_nxt = S_WAIT2;
      S_WAIT2: if (sts.div_done) state_nxt = S_PUB;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == S_IDLE) && start;
    cmd.rd      = (state_r == S_RD);
    cmd.chk     = (state_r == S_CHK);
    cmd.eval    = (state_r == S_EVAL);
    cmd.tko     = (state_r == S_TKO);
    cmd.rsv     = (state_r == S_RSV);
    cmd.abt     = (state_r == S_ABT);
    cmd.div_go  = (state_r == S_DIV1) || (state_r == S_DIV2);
    cmd.div_sel = (state_r == S_DIV2);
    cmd.lap     = (state_r == S_LAP);
    cmd.pub     = (state_r == S_PUB);
    cmd.clr     = (state_r == S_CLEAR);
    cmd.fin     = (state_r == S_FIN);
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* rtl/dedup_slot_table_claim.sv */
// top level of the dedup slot table: controller, datapath and config port
// depends on dstc_pkg, dstc_ctrl and dstc_dpath
// opcode 3 or an oversize claim skips the slot checks; other items probe the window
// and an applied publish then adds two 64-step remainder passes on the arena size
// one item at a time, with a read state and a check state for each slot of the probe
// after reset a clear of all 1024 slots holds busy high; results cannot be stalled
module dedup_slot_table_claim import dstc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [40:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  dstc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  dstc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work in progress");

endmodule

/* bench/tb.sv */
// testbench of the dedup slot table: directed table then random claim/publish/abort traffic
// depends on dstc_pkg and dedup_slot_table_claim; predicts every result beat and compares
`timescale 1ns / 100ps
module tb;
  import dstc_pkg::*;

  localparam int LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_TTL;
  logic [40:0] cfg_wdata = '0;

  dedup_slot_table_claim u_dut (.*);

  always #2 clk = ~clk;

  typedef struct {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic [1:0]  tbl_status [SLOT_COUNT];
  logic [63:0] tbl_id [SLOT_COUNT];
  logic [31:0] tbl_index [SLOT_COUNT];
  logic        tbl_kind [SLOT_COUNT];
  logic [63:0] tbl_stamp [SLOT_COUNT];
  logic [31:0] tbl_len [SLOT_COUNT];
  logic [39:0] tbl_off [SLOT_COUNT];
  logic [63:0] tbl_lap [SLOT_COUNT];
  logic [63:0] cursor;
  logic [31:0] ttl;
  logic [31:0] takeover;
  logic [40:0] arena;

  out_item_t   pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  logic [63:0] clock_ms = 64'd100;
  logic [63:0] hot_ids [8];
  logic [31:0] hot_idx [8];

  function automatic int home_of(logic [63:0] id, logic [31:0] idx, logic k);
    logic [63:0] h;
    h = id ^ (id >> 32) ^ {32'd0, idx} ^ ({63'd0, k} << 13);
    return int'(h[SLOT_AW-1:0]);
  endfunction

  function automatic int find_slot(logic [63:0] id, logic [31:0] idx, logic k);
    int i;
    i = home_of(id, idx, k);
    for (int p = 0; p < PROBE_WINDOW; p++) begin
      if (tbl_status[i] != ST_EMPTY && tbl_id[i] == id && tbl_index[i] == idx
          && tbl_kind[i] == k)
        return i;
      i = (i + 1) % SLOT_COUNT;
    end
    return -1;
  endfunction

  task automatic take_slot(logic [63:0] id, logic [31:0] idx, logic k, logic [63:0] t);
    int i;
    logic [63:0] d;
    i = home_of(id, idx, k);
    for (int p = 0; p < PROBE_WINDOW; p++) begin
      d = t - tbl_stamp[i];
      if (tbl_status[i] == ST_EMPTY || (tbl_status[i] == ST_READY && d > {32'd0, ttl})) begin
        tbl_status[i] = ST_FETCHING;
        tbl_id[i] = id; tbl_index[i] = idx; tbl_kind[i] = k;
        tbl_len[i] = '0; tbl_off[i] = '0; tbl_lap[i] = '0; tbl_stamp[i] = t;
        return;
      end
      i = (i + 1) % SLOT_COUNT;
    end
  endtask

  function automatic logic payload_usable(int i, logic [31:0] cap, logic exact);
    logic [64:0] n, a;
    n = {33'd0, tbl_len[i]};
    a = {24'd0, arena};
    if (exact && tbl_len[i] != cap) return 1'b0;
    if (tbl_len[i] > cap) return 1'b0;
    if ({25'd0, tbl_off[i]} + n > a) return 1'b0;
    if ({1'b0, cursor - tbl_lap[i]} > {1'b0, 64'(a) - 64'(n)}) return 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_result(in_item_t it, output out_item_t r);
    int s;
    logic [63:0] d, a, inlap, need, fin, off;
    logic done;
    r = '0;
    r.role = ROLE_ACK;
    a = {23'd0, arena};
    case (it.opcode)
      OP_CLAIM: begin
        r.role = ROLE_FETCH;
        if (it.size_bytes != 0 && {32'd0, it.size_bytes} <= a / 2) begin
          s = find_slot(it.key_id, it.key_idx, it.key_kind);
          done = 1'b0;
          if (s >= 0 && tbl_status[s] == ST_READY) begin
            d = it.now_ms - tbl_stamp[s];
            if (d <= {32'd0, ttl} && payload_usable(s, it.size_bytes, it.exact_length)) begin
              r.role = ROLE_HIT;
              r.payload_offset = tbl_off[s];
              r.payload_length = tbl_len[s];
              done = 1'b1;
            end
          end else if (s >= 0 && tbl_status[s] == ST_FETCHING) begin
            d = it.now_ms - tbl_stamp[s];
            if (d <= {32'd0, takeover}) r.role = ROLE_WAIT;
            else tbl_stamp[s] = it.now_ms;
            done = 1'b1;
          end
          if (!done) take_slot(it.key_id, it.key_idx, it.key_kind, it.now_ms);
        end
      end
      OP_PUBLISH: begin
        s = find_slot(it.key_id, it.key_idx, it.key_kind);
        if (s >= 0 && tbl_status[s] == ST_FETCHING && a != 0) begin
          inlap = cursor % a;
          need = (inlap + it.size_bytes > a) ? (a - inlap) + it.size_bytes
                                             : {32'd0, it.size_bytes};
          fin = cursor + need;
          off = (fin - it.size_bytes) % a;
          cursor = fin;
          tbl_len[s] = it.size_bytes; tbl_off[s] = off[39:0]; tbl_lap[s] = fin;
          tbl_stamp[s] = it.now_ms; tbl_status[s] = ST_READY;
          r.applied = 1'b1;
          r.payload_offset = off[39:0];
          r.payload_length = it.size_bytes;
        end
      end
      OP_ABORT: begin
        s = find_slot(it.key_id, it.key_idx, it.key_kind);
        if (s >= 0 && tbl_status[s] == ST_FETCHING) begin
          tbl_status[s] = ST_EMPTY;
          r.applied = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    out_item_t r;
    predict_result(it, r);
    if (typed && r !== want)
      $display("%0t predictor disagrees with table: expected %h got %h", $time, want, r);
    pending_results.push_back(typed ? want : r);
    in_item <= it;
    start <= 1'b1;
    // busy is stable mid-cycle, the beat goes at the next rising edge
    do @(negedge clk); while (busy);
    @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [40:0] v);
    cfg_index <= idx;
    cfg_wdata <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TTL: ttl = v[31:0];
      CFG_TAKEOVER: takeover = v[31:0];
      default: arena = v;
    endcase
  endtask

  function automatic in_item_t mk(logic [1:0] op, logic [63:0] id, logic [31:0] idx,
                                   logic k, logic [63:0] t, logic [31:0] sz, logic ex);
    in_item_t it;
    it.opcode = op; it.key_id = id; it.key_idx = idx; it.key_kind = k;
    it.now_ms = t; it.size_bytes = sz; it.exact_length = ex;
    return it;
  endfunction

  function automatic out_item_t res(logic [1:0] role);
    out_item_t r;
    r = '0;
    r.role = role;
    return r;
  endfunction

  function automatic in_item_t random_item(int mode);
    in_item_t it;
    int h;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    h = $urandom_range(0, 7);
    if (mode != 0) begin
      it.key_id = hot_ids[h];
      it.key_idx = hot_idx[h];
      it.key_kind = h[0];
      it.opcode = ($urandom_range(0, 2) == 0) ? OP_PUBLISH : OP_CLAIM;
      if ($urandom_range(0, 7) == 0) it.opcode = OP_ABORT;
      clock_ms = clock_ms + $urandom_range(0, 400);
      it.now_ms = clock_ms;
      it.size_bytes = $urandom_range(1, 3000);
      it.exact_length = ($urandom_range(0, 3) == 0);
    end
    return it;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result beat %h", $time, out_item);
        errors <= errors + 1;
      end else if (out_item !== pending_results[0]) begin
        $display("%0t mismatch expected %h actual %h", $time, pending_results[0], out_item);
        errors <= errors + 1;
        void'(pending_results.pop_front());
      end else begin
        void'(pending_results.pop_front());
      end
    end
  end

  stim_row_t   rows[$];
  out_item_t   hit_r;

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tbl_status[i] = ST_EMPTY; tbl_id[i] = '0; tbl_index[i] = '0; tbl_kind[i] = 0;
      tbl_stamp[i] = '0; tbl_len[i] = '0; tbl_off[i] = '0; tbl_lap[i] = '0;
    end
    cursor = '0; ttl = 5000; takeover = 2000; arena = 41'd536870912;
    for (int i = 0; i < 8; i++) begin
      hot_ids[i] = {$urandom, $urandom};
      hot_idx[i] = (i < 4) ? 32'(i) : $urandom;
    end
    hot_ids[7] = hot_ids[6] ^ 64'h400;  // same home slot as its neighbour
    hot_idx[7] = hot_idx[6];

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    hit_r = '0; hit_r.role = ROLE_HIT; hit_r.payload_length = 32'd64;
    rows.push_back('{mk(OP_CLAIM, 64'd1, 32'd0, 1'b0, 64'd10, 32'd0, 1'b0), 1, res(ROLE_FETCH)});
    rows.push_back('{mk(OP_NONE, '1, '1, 1'b1, '1, '1, 1'b1), 1, res(ROLE_ACK)});
    rows.push_back('{mk(OP_ABORT, 64'd5, 32'd5, 1'b0, 64'd10, 32'd0, 1'b0), 1, res(ROLE_ACK)});
    rows.push_back('{mk(OP_CLAIM, '1, '1, 1'b1, 64'd10, 32'hFFFF_FFFF, 1'b0), 1,
                     res(ROLE_FETCH)});
    rows.push_back('{mk(OP_CLAIM, 64'd1, 32'd0, 1'b0, 64'd10, 32'd64, 1'b0), 1,
                     res(ROLE_FETCH)});
    rows.push_back('{mk(OP_CLAIM, 64'd1, 32'd0, 1'b0, 64'd20, 32'd64, 1'b0), 1, res(ROLE_WAIT)});
    rows.push_back('{mk(OP_PUBLISH, 64'd1, 32'd0, 1'b0, 64'd30, 32'd64, 1'b0), 0, '0});
    rows.push_back('{mk(OP_CLAIM, 64'd1, 32'd0, 1'b0, 64'd40, 32'd64, 1'b1), 1, hit_r});
    rows.push_back('{mk(OP_CLAIM, 64'd1, 32'd0, 1'b0, 64'd40, 32'd65, 1'b1), 0, '0});
    rows.push_back('{mk(OP_CLAIM, 64'd1, 32'd0, 1'b0, 64'd40, 32'd32, 1'b0), 0, '0});
    rows.push_back('{mk(OP_CLAIM, 64'd1, 32'd0, 1'b1, 64'd50, 32'd8, 1'b0), 0, '0});
    rows.push_back('{mk(OP_CLAIM, 64'd1, 32'd0, 1'b1, 64'd9000, 32'd8, 1'b0), 0, '0});
    rows.push_back('{mk(OP_ABORT, 64'd1, 32'd0, 1'b1, 64'd9000, 32'd0, 1'b0), 0, '0});
    rows.push_back('{mk(OP_CLAIM, 64'd1, 32'd0, 1'b0, 64'd99999, 32'd64, 1'b0), 0, '0});
    rows.push_back('{mk(OP_PUBLISH, 64'd1, 32'd0, 1'b0, 64'd99999, 32'hFFFF_FFFF, 1'b0), 0, '0});
    for (int i = 0; i < 9; i++)
      rows.push_back('{mk(OP_CLAIM, 64'h0000_0400 * i, 32'd0, 1'b0, '1, 32'd16, 1'b0), 0, '0});
    rows.push_back('{mk(OP_PUBLISH, 64'h0000_0800, 32'd0, 1'b0, 64'd5, 32'd16, 1'b0), 0, '0});
    foreach (rows[i]) begin
      send_item(rows[i].item, rows[i].typed, rows[i].want);
      idle_gap();
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_TTL, 41'd0); write_reg(CFG_TAKEOVER, 41'd0);
             write_reg(CFG_ARENA, 41'd2); end
        1: begin write_reg(CFG_TTL, 41'hFFFF_FFFF); write_reg(CFG_TAKEOVER, 41'hFFFF_FFFF);
             write_reg(CFG_ARENA, 41'h100_0000_0000); end
        2: begin write_reg(CFG_TTL, 41'd600); write_reg(CFG_TAKEOVER, 41'd300);
             write_reg(CFG_ARENA, 41'd4096); end
        3: write_reg(CFG_ARENA, 41'd0);
        4: begin write_reg(CFG_ARENA, 41'h1FF_FFFF_FFFF); write_reg(CFG_TTL, 41'd1500); end
        default: begin write_reg(CFG_ARENA, 41'd10000); write_reg(CFG_TAKEOVER, 41'd900); end
      endcase
      for (int n = 0; n < 85; n++) begin
        send_item(random_item($urandom_range(0, 4)), 1'b0, '0);
        idle_gap();
      end
      drain();
    end

    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule

/* files.f */
rtl/dstc_pkg.sv
rtl/dstc_rem_div.sv
rtl/dstc_dpath.sv
rtl/dstc_ctrl.sv
rtl/dedup_slot_table_claim.sv
bench/tb.sv
